// ===== rtl/obb_pkg.sv =====
package obb_pkg;

  localparam int unsigned EPS_LSB = 2;

  typedef struct packed {
    logic valid;
    logic hold;
  } obb_ctl_t;

endpackage

// ===== rtl/obb_pair_overlap_test.sv =====
// Registers in order: frame products, frame sums, SAT terms, SAT compare flag, output.
// One item per cycle unless stalled; the pipeline advances while the output stage is free.
// While a result waits under stall, the whole pipeline holds and the input is stalled.
// Reset clears all valid bits; the data registers are not reset.
module obb_pair_overlap_test #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [3*COMPONENT_BITS-1:0]   a_center_i,
  input  logic [3*COMPONENT_BITS-1:0]   a_axis_one_i,
  input  logic [3*COMPONENT_BITS-1:0]   a_axis_two_i,
  input  logic [3*COMPONENT_BITS-1:0]   a_axis_three_i,
  input  logic [3*COMPONENT_BITS-1:0]   a_half_i,
  input  logic [3*COMPONENT_BITS-1:0]   b_center_i,
  input  logic [3*COMPONENT_BITS-1:0]   b_axis_one_i,
  input  logic [3*COMPONENT_BITS-1:0]   b_axis_two_i,
  input  logic [3*COMPONENT_BITS-1:0]   b_axis_three_i,
  input  logic [3*COMPONENT_BITS-1:0]   b_half_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          overlap_o
);

  localparam int unsigned CB = COMPONENT_BITS;

  obb_pkg::obb_ctl_t ctl;
  logic adv;
  logic fv;
  logic sv;
  logic sep;
  logic signed [CB+2:0] r [3][3];
  logic signed [CB+3:0] t [3];
  logic [3*CB-1:0] ha_q [2];
  logic [3*CB-1:0] hb_q [2];

  assign ctl.hold = out_valid_o && out_stall_i;
  assign ctl.valid = sv;
  assign adv = !ctl.hold;
  assign in_stall_o = ctl.hold;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ha_q[0] <= a_half_i;
      hb_q[0] <= b_half_i;
      ha_q[1] <= ha_q[0];
      hb_q[1] <= hb_q[0];
    end
  end

  obb_frame #(.CB(CB)) u_frame (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_valid_i),
    .a_center_i, .a_axis_one_i, .a_axis_two_i, .a_axis_three_i,
    .b_center_i, .b_axis_one_i, .b_axis_two_i, .b_axis_three_i,
    .valid_o(fv), .r_o(r), .t_o(t)
  );

  obb_sat #(.CB(CB)) u_sat (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(fv), .r_i(r), .t_i(t),
    .ha_i(ha_q[1]), .hb_i(hb_q[1]), .valid_o(sv), .sep_o(sep)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      overlap_o <= !sep;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.hold |=> out_valid_o) else $error("result lost during stall");
  a_hold_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.hold |=> $stable(overlap_o)) else $error("result changed during stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("stall without pending result");

endmodule

// ===== rtl/obb_frame.sv =====
module obb_frame #(
  parameter int unsigned CB = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic [3*CB-1:0]        a_center_i,
  input  logic [3*CB-1:0]        a_axis_one_i,
  input  logic [3*CB-1:0]        a_axis_two_i,
  input  logic [3*CB-1:0]        a_axis_three_i,
  input  logic [3*CB-1:0]        b_center_i,
  input  logic [3*CB-1:0]        b_axis_one_i,
  input  logic [3*CB-1:0]        b_axis_two_i,
  input  logic [3*CB-1:0]        b_axis_three_i,
  output logic                   valid_o,
  output logic signed [CB+2:0]   r_o [3][3],
  output logic signed [CB+3:0]   t_o [3]
);

  localparam int unsigned FRAC = CB - 2;
  localparam int unsigned PW = 2 * CB + 4;

  logic signed [CB-1:0] ax [3][3];
  logic signed [CB-1:0] bx [3][3];
  logic signed [CB:0] dc [3];
  logic signed [PW-1:0] rp_d [3][3][3];
  logic signed [PW-1:0] rp_q [3][3][3];
  logic signed [PW-1:0] tp_d [3][3];
  logic signed [PW-1:0] tp_q [3][3];
  logic signed [CB+2:0] r_d [3][3];
  logic signed [CB+3:0] t_d [3];
  logic v1_q;
  logic signed [PW-1:0] s;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[0][k] = a_axis_one_i[k*CB +: CB];
      ax[1][k] = a_axis_two_i[k*CB +: CB];
      ax[2][k] = a_axis_three_i[k*CB +: CB];
      bx[0][k] = b_axis_one_i[k*CB +: CB];
      bx[1][k] = b_axis_two_i[k*CB +: CB];
      bx[2][k] = b_axis_three_i[k*CB +: CB];
      dc[k] = (CB+1)'($signed(b_center_i[k*CB +: CB]))
            - (CB+1)'($signed(a_center_i[k*CB +: CB]));
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        tp_d[i][k] = PW'(dc[k]) * PW'(ax[i][k]);
        for (int j = 0; j < 3; j++) begin
          rp_d[i][j][k] = PW'(ax[i][k]) * PW'(bx[j][k]);
        end
      end
    end
  end

  always_comb begin
    s = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s = rp_q[i][j][0] + rp_q[i][j][1] + rp_q[i][j][2] + PW'(1 << (FRAC - 1));
        r_d[i][j] = (CB+3)'(s >>> FRAC);
      end
      s = tp_q[i][0] + tp_q[i][1] + tp_q[i][2] + PW'(1 << (FRAC - 1));
      t_d[i] = (CB+4)'(s >>> FRAC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rp_q <= rp_d;
      tp_q <= tp_d;
      r_o <= r_d;
      t_o <= t_d;
    end
  end

endmodule

// ===== rtl/obb_sat.sv =====
module obb_sat #(
  parameter int unsigned CB = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic signed [CB+2:0]   r_i [3][3],
  input  logic signed [CB+3:0]   t_i [3],
  input  logic [3*CB-1:0]        ha_i,
  input  logic [3*CB-1:0]        hb_i,
  output logic                   valid_o,
  output logic                   sep_o
);

  localparam int unsigned FRAC = CB - 2;
  localparam int unsigned W = 2 * CB + 12;

  logic signed [W-1:0] ar [3][3];
  logic signed [W-1:0] rr [3][3];
  logic signed [W-1:0] tt [3];
  logic signed [W-1:0] ha [3];
  logic signed [W-1:0] hb [3];
  logic signed [W-1:0] lhs_d [15][3];
  logic signed [W-1:0] rhs_d [15][3];
  logic signed [W-1:0] lhs_q [15][3];
  logic signed [W-1:0] rhs_q [15][3];
  logic [14:0] sep_d;
  logic signed [W-1:0] l;
  logic v1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tt[i] = W'(t_i[i]);
      ha[i] = W'({1'b0, ha_i[i*CB +: CB]});
      hb[i] = W'({1'b0, hb_i[i*CB +: CB]});
      for (int j = 0; j < 3; j++) begin
        rr[i][j] = W'(r_i[i][j]);
        ar[i][j] = (r_i[i][j] < 0 ? -rr[i][j] : rr[i][j]) + W'(obb_pkg::EPS_LSB);
      end
    end
    for (int i = 0; i < 3; i++) begin
      lhs_d[i][0] = (tt[i] < 0 ? -tt[i] : tt[i]) <<< FRAC;
      lhs_d[i][1] = '0;
      lhs_d[i][2] = '0;
      rhs_d[i][0] = (ha[i] <<< FRAC) + hb[0] * ar[i][0];
      rhs_d[i][1] = hb[1] * ar[i][1];
      rhs_d[i][2] = hb[2] * ar[i][2];
      lhs_d[3+i][0] = tt[0] * rr[0][i];
      lhs_d[3+i][1] = tt[1] * rr[1][i];
      lhs_d[3+i][2] = tt[2] * rr[2][i];
      rhs_d[3+i][0] = (hb[i] <<< FRAC) + ha[0] * ar[0][i];
      rhs_d[3+i][1] = ha[1] * ar[1][i];
      rhs_d[3+i][2] = ha[2] * ar[2][i];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        lhs_d[6+3*i+j][0] = tt[(i+2)%3] * rr[(i+1)%3][j];
        lhs_d[6+3*i+j][1] = -(tt[(i+1)%3] * rr[(i+2)%3][j]);
        lhs_d[6+3*i+j][2] = '0;
        rhs_d[6+3*i+j][0] = ha[(i+1)%3] * ar[(i+2)%3][j];
        rhs_d[6+3*i+j][1] = ha[(i+2)%3] * ar[(i+1)%3][j];
        rhs_d[6+3*i+j][2] = hb[(j+1)%3] * ar[i][(j+2)%3] + hb[(j+2)%3] * ar[i][(j+1)%3];
      end
    end
  end

  always_comb begin
    l = '0;
    for (int n = 0; n < 15; n++) begin
      l = lhs_q[n][0] + lhs_q[n][1] + lhs_q[n][2];
      if (l < 0) begin
        l = -l;
      end
      sep_d[n] = l > (rhs_q[n][0] + rhs_q[n][1] + rhs_q[n][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
      sep_o <= |sep_d;
    end
  end

endmodule
